### rtl/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg
// shared types, codes and helpers of the png scanline unfilter block
// ----------------------------------------------------------------------------
package pngu_pkg;

  localparam int unsigned MAX_WIDTH_DEF     = 2048;
  localparam int unsigned ROW_BYTES_DEF     = 8192;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  localparam logic [2:0] MODE_GRAY       = 3'd0;
  localparam logic [2:0] MODE_RGB        = 3'd1;
  localparam logic [2:0] MODE_INDEXED    = 3'd2;
  localparam logic [2:0] MODE_GRAY_ALPHA = 3'd3;
  localparam logic [2:0] MODE_RGBA       = 3'd4;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic [2:0] CFG_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_MODE      = 3'd2;
  localparam logic [2:0] CFG_KEY_EN    = 3'd3;
  localparam logic [2:0] CFG_KEY_RED   = 3'd4;
  localparam logic [2:0] CFG_KEY_GREEN = 3'd5;
  localparam logic [2:0] CFG_KEY_BLUE  = 3'd6;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [11:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  color_mode;
    logic        key_enable;
    logic [7:0]  key_red;
    logic [7:0]  key_green;
    logic [7:0]  key_blue;
  } cfg_t;

  typedef struct packed {
    logic       func;
    logic [7:0] stream_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] entry_alpha;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_PIX,
    OP_PAL,
    OP_BAD
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [2:0] filt;
    logic       upper_ok;
    logic       first;
    logic [1:0] chan;
    logic       emit;
    logic       row_end;
    logic       image_end;
    in_word_t   word;
  } op_t;

  function automatic logic [2:0] channels(logic [2:0] mode);
    logic [2:0] n;
    case (mode)
      MODE_RGB:        n = 3'd3;
      MODE_GRAY_ALPHA: n = 3'd2;
      MODE_RGBA:       n = 3'd4;
      default:         n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] paeth(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [7:0]        r;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) r = a;
    else if (db <= dc)        r = b;
    else                      r = c;
    return r;
  endfunction

endpackage

### rtl/pngu_ram.sv
// ----------------------------------------------------------------------------
// pngu_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pngu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pngu_fifo.sv
// ----------------------------------------------------------------------------
// pngu_fifo
// two entry queue
// ----------------------------------------------------------------------------
module pngu_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] data_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/pngu_front.sv
// ----------------------------------------------------------------------------
// pngu_front
// takes stream words, tracks filter bytes, rows and columns, issues ops
// ----------------------------------------------------------------------------
module pngu_front #(
  parameter int unsigned MAX_WIDTH = pngu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned ROW_BYTES = pngu_pkg::ROW_BYTES_DEF,
  localparam int unsigned COL_W = $clog2(ROW_BYTES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pngu_pkg::cfg_t     cfg_i,
  input  logic               push_i,
  input  pngu_pkg::in_word_t in_word_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output pngu_pkg::op_t      q_op_o,
  output logic [COL_W-1:0]   q_col_o
);

  localparam logic [17:0] CAP1  = 18'(ROW_BYTES);
  localparam logic [17:0] CAP2  = 18'(ROW_BYTES / 2);
  localparam logic [17:0] CAP3  = 18'(ROW_BYTES / 3);
  localparam logic [17:0] CAP4  = 18'(ROW_BYTES / 4);
  localparam logic [17:0] WMAX  = 18'(MAX_WIDTH);

  logic             await_q, err_q;
  logic [2:0]       filt_q;
  logic [COL_W-1:0] col_q;
  logic [15:0]      row_q;
  logic [1:0]       col_mod3_q;

  logic             acc;
  logic [2:0]       ch;
  logic [1:0]       chan;
  logic [17:0]      wv, stride, colp1;
  logic [16:0]      hv, rowp1;
  logic             row_end, last_row, last_ch, bad;

  assign acc = push_i && !q_full_i;
  assign ch  = pngu_pkg::channels(cfg_i.color_mode);
  assign bad = (in_word_i.stream_byte > 8'd4);

  always_comb begin
    wv = (cfg_i.image_width == 12'd0) ? 18'd1 : {6'd0, cfg_i.image_width};
    if (wv > WMAX) wv = WMAX;
    case (ch)
      3'd2:    if (wv > CAP2) wv = CAP2;
      3'd3:    if (wv > CAP3) wv = CAP3;
      3'd4:    if (wv > CAP4) wv = CAP4;
      default: if (wv > CAP1) wv = CAP1;
    endcase
    case (ch)
      3'd2:    stride = wv << 1;
      3'd3:    stride = wv + (wv << 1);
      3'd4:    stride = wv << 2;
      default: stride = wv;
    endcase
  end

  // channel slot of the byte is the column modulo the channel count
  always_comb begin
    case (ch)
      3'd2:    chan = {1'b0, col_q[0]};
      3'd3:    chan = col_mod3_q;
      3'd4:    chan = col_q[1:0];
      default: chan = 2'd0;
    endcase
  end

  assign colp1    = 18'(col_q) + 18'd1;
  assign row_end  = (colp1 >= stride);
  assign hv       = (cfg_i.image_height == 16'd0) ? 17'd1 : {1'b0, cfg_i.image_height};
  assign rowp1    = {1'b0, row_q} + 17'd1;
  assign last_row = (rowp1 >= hv);
  assign last_ch  = ({1'b0, chan} == (ch - 3'd1));

  always_comb begin
    q_op_o           = '0;
    q_op_o.word      = in_word_i;
    q_op_o.filt      = filt_q;
    q_op_o.upper_ok  = (row_q != 16'd0);
    q_op_o.first     = (col_q == '0);
    q_op_o.chan      = chan;
    q_op_o.emit      = last_ch || row_end;
    q_op_o.row_end   = row_end;
    q_op_o.image_end = row_end && last_row;
    q_op_o.kind      = pngu_pkg::OP_PIX;
    q_push_o         = 1'b0;
    if (acc) begin
      if (in_word_i.func) begin
        q_op_o.kind = pngu_pkg::OP_PAL;
        q_push_o    = 1'b1;
      end else if (!err_q) begin
        if (await_q) begin
          q_op_o.kind = pngu_pkg::OP_BAD;
          q_push_o    = bad;
        end else begin
          q_push_o = 1'b1;
        end
      end
    end
  end

  assign q_col_o = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q    <= 1'b1;
      err_q      <= 1'b0;
      filt_q     <= pngu_pkg::FILT_NONE;
      col_q      <= '0;
      row_q      <= '0;
      col_mod3_q <= '0;
    end else if (acc && !in_word_i.func && !err_q) begin
      if (await_q) begin
        if (bad) begin
          err_q <= 1'b1;
        end else begin
          filt_q     <= in_word_i.stream_byte[2:0];
          await_q    <= 1'b0;
          col_q      <= '0;
          col_mod3_q <= '0;
        end
      end else begin
        if (row_end) begin
          await_q    <= 1'b1;
          col_q      <= '0;
          col_mod3_q <= '0;
          row_q      <= last_row ? 16'd0 : rowp1[15:0];
        end else begin
          col_q      <= colp1[COL_W-1:0];
          col_mod3_q <= (col_mod3_q == 2'd2) ? 2'd0 : col_mod3_q + 2'd1;
        end
      end
    end
  end

endmodule

### rtl/pngu_back.sv
// ----------------------------------------------------------------------------
// pngu_back
// unfilter stage against the row buffer, then palette and rgba stage
// ----------------------------------------------------------------------------
module pngu_back #(
  parameter int unsigned ROW_BYTES     = pngu_pkg::ROW_BYTES_DEF,
  parameter int unsigned PALETTE_DEPTH = pngu_pkg::PALETTE_DEPTH_DEF,
  localparam int unsigned COL_W = $clog2(ROW_BYTES),
  localparam int unsigned PW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pngu_pkg::cfg_t      cfg_i,
  input  logic                q_empty_i,
  input  pngu_pkg::op_t       q_op_i,
  input  logic [COL_W-1:0]    q_col_i,
  output logic                q_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output pngu_pkg::out_word_t res_word_o
);

  localparam logic [8:0] PDEPTH = 9'(PALETTE_DEPTH);

  logic                x_v_q, fwd_q;
  pngu_pkg::op_t       x_op_q;
  logic [COL_W-1:0]    x_col_q;
  logic [7:0]          fwd_d_q;
  logic [31:0]         left_q, upper_q;
  logic [23:0]         pend_q;

  logic                y_v_q, y_bad_q, y_row_end_q, y_image_end_q, y_pvalid_q, y_inrange_q;
  logic [31:0]         y_s_q;
  logic [PALETTE_DEPTH-1:0] pvalid_q;

  logic        y_go, y_ready, x_go, ld, x_pix, x_pal, x_emits;
  logic [2:0]  ch;
  logic [31:0] left_eff, upper_eff;
  logic [23:0] pend_eff, pend_d;
  logic [7:0]  a, b, c, v, rd_row;
  logic [31:0] s;
  logic [31:0] pal_rd;
  logic        pal_we;

  assign y_go    = y_v_q && !res_full_i;
  assign y_ready = !y_v_q || y_go;
  assign x_go    = x_v_q && y_ready;
  assign ld      = !q_empty_i && (!x_v_q || x_go);
  assign q_pop_o = ld;
  assign x_pix   = (x_op_q.kind == pngu_pkg::OP_PIX);
  assign x_pal   = (x_op_q.kind == pngu_pkg::OP_PAL);
  assign x_emits = (x_op_q.kind == pngu_pkg::OP_BAD) || (x_pix && x_op_q.emit);
  assign ch      = pngu_pkg::channels(cfg_i.color_mode);

  pngu_ram #(.WIDTH(8), .DEPTH(ROW_BYTES)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (x_go && x_pix),
    .waddr_i (x_col_q),
    .wdata_i (v),
    .re_i    (ld),
    .raddr_i (q_col_i),
    .rdata_o (rd_row)
  );

  assign pal_we = x_go && x_pal && ({1'b0, x_op_q.word.entry_index} < PDEPTH);

  pngu_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (x_op_q.word.entry_index[PW-1:0]),
    .wdata_i ({x_op_q.word.entry_red, x_op_q.word.entry_green,
               x_op_q.word.entry_blue, x_op_q.word.entry_alpha}),
    .re_i    (x_go && x_pix && x_op_q.emit),
    .raddr_i (v[PW-1:0]),
    .rdata_o (pal_rd)
  );

  always_comb begin
    left_eff  = x_op_q.first ? 32'd0 : left_q;
    upper_eff = x_op_q.first ? 32'd0 : upper_q;
    case (ch)
      3'd2:    begin a = left_eff[15:8];  c = upper_eff[15:8];  end
      3'd3:    begin a = left_eff[23:16]; c = upper_eff[23:16]; end
      3'd4:    begin a = left_eff[31:24]; c = upper_eff[31:24]; end
      default: begin a = left_eff[7:0];   c = upper_eff[7:0];   end
    endcase
    b = x_op_q.upper_ok ? (fwd_q ? fwd_d_q : rd_row) : 8'd0;
    case (x_op_q.filt)
      pngu_pkg::FILT_SUB:   v = x_op_q.word.stream_byte + a;
      pngu_pkg::FILT_UP:    v = x_op_q.word.stream_byte + b;
      pngu_pkg::FILT_AVG:   v = x_op_q.word.stream_byte + 8'(({1'b0, a} + {1'b0, b}) >> 1);
      pngu_pkg::FILT_PAETH: v = x_op_q.word.stream_byte + pngu_pkg::paeth(a, b, c);
      default:              v = x_op_q.word.stream_byte;
    endcase
    pend_eff = (x_op_q.chan == 2'd0) ? 24'd0 : pend_q;
    case (x_op_q.chan)
      2'd0: begin
        s      = {24'd0, v};
        pend_d = {16'd0, v};
      end
      2'd1: begin
        s      = {16'd0, v, pend_eff[7:0]};
        pend_d = pend_eff | {8'd0, v, 8'd0};
      end
      2'd2: begin
        s      = {8'd0, v, pend_eff[15:0]};
        pend_d = pend_eff | {v, 16'd0};
      end
      default: begin
        s      = {v, pend_eff};
        pend_d = pend_eff;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_v_q    <= 1'b0;
      y_v_q    <= 1'b0;
      fwd_q    <= 1'b0;
      pvalid_q <= '0;
    end else begin
      if (ld)        x_v_q <= 1'b1;
      else if (x_go) x_v_q <= 1'b0;
      if (x_go && x_emits) y_v_q <= 1'b1;
      else if (y_go)       y_v_q <= 1'b0;
      if (ld)        fwd_q <= x_go && x_pix && (x_col_q == q_col_i);
      else if (x_go) fwd_q <= 1'b0;
      if (pal_we) pvalid_q[x_op_q.word.entry_index[PW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      x_op_q  <= q_op_i;
      x_col_q <= q_col_i;
      fwd_d_q <= v;
    end
    if (x_go && x_pix) begin
      left_q  <= {left_eff[23:0], v};
      upper_q <= {upper_eff[23:0], b};
      pend_q  <= pend_d;
    end
    if (x_go && x_emits) begin
      y_bad_q       <= !x_pix;
      y_s_q         <= s;
      y_row_end_q   <= x_op_q.row_end;
      y_image_end_q <= x_op_q.image_end;
      y_inrange_q   <= ({1'b0, v} < PDEPTH);
      y_pvalid_q    <= pvalid_q[v[PW-1:0]];
    end
  end

  always_comb begin
    res_word_o           = '0;
    res_word_o.alpha     = pngu_pkg::ALPHA_OPAQUE;
    res_word_o.row_end   = y_row_end_q;
    res_word_o.image_end = y_image_end_q;
    case (cfg_i.color_mode)
      pngu_pkg::MODE_RGB: begin
        res_word_o.red   = y_s_q[7:0];
        res_word_o.green = y_s_q[15:8];
        res_word_o.blue  = y_s_q[23:16];
        if (cfg_i.key_enable && y_s_q[7:0] == cfg_i.key_red &&
            y_s_q[15:8] == cfg_i.key_green && y_s_q[23:16] == cfg_i.key_blue) begin
          res_word_o.alpha = 8'd0;
        end
      end
      pngu_pkg::MODE_INDEXED: begin
        if (y_inrange_q && y_pvalid_q) begin
          res_word_o.red   = pal_rd[31:24];
          res_word_o.green = pal_rd[23:16];
          res_word_o.blue  = pal_rd[15:8];
          res_word_o.alpha = pal_rd[7:0];
        end
      end
      pngu_pkg::MODE_GRAY_ALPHA: begin
        res_word_o.red   = y_s_q[7:0];
        res_word_o.green = y_s_q[7:0];
        res_word_o.blue  = y_s_q[7:0];
        res_word_o.alpha = y_s_q[15:8];
      end
      pngu_pkg::MODE_RGBA: begin
        res_word_o.red   = y_s_q[7:0];
        res_word_o.green = y_s_q[15:8];
        res_word_o.blue  = y_s_q[23:16];
        res_word_o.alpha = y_s_q[31:24];
      end
      default: begin
        res_word_o.red   = y_s_q[7:0];
        res_word_o.green = y_s_q[7:0];
        res_word_o.blue  = y_s_q[7:0];
        if (cfg_i.key_enable && y_s_q[7:0] == cfg_i.key_red) res_word_o.alpha = 8'd0;
      end
    endcase
    if (y_bad_q) begin
      res_word_o            = '0;
      res_word_o.bad_filter = 1'b1;
    end
  end

  assign res_push_o = y_go;

  a_x_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_v_q && !x_go) |=> (x_v_q && $stable(x_col_q) && $stable(x_op_q)))
    else $error("unfilter stage lost its op while stalled");

  a_y_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (y_v_q && !y_go) |=> y_v_q)
    else $error("result stage dropped a word");

  a_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> x_v_q)
    else $error("row forward flag without an op");

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_word_o.bad_filter) |->
      (res_word_o.red == 8'd0 && res_word_o.alpha == 8'd0 && !res_word_o.row_end))
    else $error("bad filter word carries pixel data");

endmodule

### rtl/png_scanline_unfilter_to_rgba.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_to_rgba
// unfilters an 8-bit png byte stream and emits rgba pixels
// ----------------------------------------------------------------------------
// throughput: one word per cycle, stream bytes and palette writes alike, when the
//   output queue is not full; an accepted push passes through the op queue, the
//   unfilter stage with row buffer read and the palette stage to the output queue
// the row buffer read is issued as an op enters the unfilter stage, bypassed for the byte just written
// reset: control state and palette valid bits cleared at once, config registers cleared
//   but width and height set to 1; row buffer is not cleared
module png_scanline_unfilter_to_rgba #(
  parameter int unsigned MAX_WIDTH     = pngu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned ROW_BYTES     = pngu_pkg::ROW_BYTES_DEF,
  parameter int unsigned PALETTE_DEPTH = pngu_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  pngu_pkg::in_word_t  in_word_i,
  output logic                empty,
  input  logic                pop,
  output pngu_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned COL_W = $clog2(ROW_BYTES);
  localparam int unsigned OPW   = $bits(pngu_pkg::op_t);
  localparam int unsigned QW    = OPW + COL_W;

  pngu_pkg::cfg_t      cfg_q;
  logic                q_push, q_pop, q_empty, res_push, res_full;
  pngu_pkg::op_t       f_op, b_op;
  logic [COL_W-1:0]    f_col;
  logic [QW-1:0]       q_rdata;
  pngu_pkg::out_word_t res_word;
  logic [$bits(pngu_pkg::out_word_t)-1:0] out_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q              <= '0;
      cfg_q.image_width  <= 12'd1;
      cfg_q.image_height <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pngu_pkg::CFG_WIDTH:     cfg_q.image_width  <= cfg_data_i[11:0];
        pngu_pkg::CFG_HEIGHT:    cfg_q.image_height <= cfg_data_i;
        pngu_pkg::CFG_MODE:      cfg_q.color_mode   <= cfg_data_i[2:0];
        pngu_pkg::CFG_KEY_EN:    cfg_q.key_enable   <= cfg_data_i[0];
        pngu_pkg::CFG_KEY_RED:   cfg_q.key_red      <= cfg_data_i[7:0];
        pngu_pkg::CFG_KEY_GREEN: cfg_q.key_green    <= cfg_data_i[7:0];
        pngu_pkg::CFG_KEY_BLUE:  cfg_q.key_blue     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  pngu_front #(.MAX_WIDTH(MAX_WIDTH), .ROW_BYTES(ROW_BYTES)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .in_word_i (in_word_i),
    .q_full_i  (full),
    .q_push_o  (q_push),
    .q_op_o    (f_op),
    .q_col_o   (f_col)
  );

  pngu_fifo #(.WIDTH(QW)) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_col, f_op}),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign b_op = pngu_pkg::op_t'(q_rdata[OPW-1:0]);

  pngu_back #(.ROW_BYTES(ROW_BYTES), .PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_op_i     (b_op),
    .q_col_i    (q_rdata[QW-1:OPW]),
    .q_pop_o    (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_word_o (res_word)
  );

  pngu_fifo #(.WIDTH($bits(pngu_pkg::out_word_t))) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_word_o = pngu_pkg::out_word_t'(out_rdata);

endmodule

### tb/sv/tb_png_scanline_unfilter_to_rgba.sv
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter_to_rgba
// self-checking testbench of the png scanline unfilter block: directed tests
// for filters, color modes, palette, key colour, size limits, live register
// changes and back-pressure, then random images and the bad filter case last;
// every accepted word is run through a local model and each popped pixel is
// compared field by field against the oldest predicted pixel
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter_to_rgba;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IN_W = $bits(pngu_pkg::in_word_t);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  pngu_pkg::in_word_t  in_word_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  pngu_pkg::out_word_t out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [15:0]         cfg_data_i = '0;

  png_scanline_unfilter_to_rgba i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // model state
  logic [11:0] m_width;
  logic [15:0] m_height;
  logic [2:0]  m_mode;
  logic        m_key_en;
  logic [7:0]  m_key_red, m_key_green, m_key_blue;
  logic [7:0]  row_mem [8192];
  logic [31:0] palette [256];
  logic [31:0] left_pix, upleft_pix;
  logic [23:0] pend_chan;
  logic [2:0]  row_filt;
  int unsigned byte_col, row_num;
  logic        want_filter, err_latched;

  pngu_pkg::out_word_t pixel_q[$];
  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned pop_hold = 0;
  bit          gaps_on = 1'b1;

  function automatic int unsigned chan_count(logic [2:0] mode);
    case (mode)
      pngu_pkg::MODE_RGB:        return 3;
      pngu_pkg::MODE_GRAY_ALPHA: return 2;
      pngu_pkg::MODE_RGBA:       return 4;
      default:                   return 1;
    endcase
  endfunction

  function automatic int unsigned row_len();
    int unsigned w;
    int unsigned ch;
    ch = chan_count(m_mode);
    w = m_width;
    if (w == 0) w = 1;
    if (w > pngu_pkg::MAX_WIDTH_DEF) w = pngu_pkg::MAX_WIDTH_DEF;
    if (w * ch > pngu_pkg::ROW_BYTES_DEF) w = pngu_pkg::ROW_BYTES_DEF / ch;
    return w * ch;
  endfunction

  function automatic int unsigned paeth_pick(int unsigned a, int unsigned b, int unsigned c);
    int p;
    int da;
    int db;
    int dc;
    p = int'(a) + int'(b) - int'(c);
    da = p - int'(a);
    db = p - int'(b);
    dc = p - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    return (db <= dc) ? b : c;
  endfunction

  task automatic model_reset();
    m_width = 1;
    m_height = 1;
    m_mode = pngu_pkg::MODE_GRAY;
    m_key_en = 0;
    m_key_red = 0;
    m_key_green = 0;
    m_key_blue = 0;
    foreach (row_mem[i]) row_mem[i] = '0;
    foreach (palette[i]) palette[i] = 32'h0000_00ff;
    left_pix = 0;
    upleft_pix = 0;
    pend_chan = 0;
    row_filt = pngu_pkg::FILT_NONE;
    byte_col = 0;
    row_num = 0;
    want_filter = 1;
    err_latched = 0;
  endtask

  task automatic model_cfg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      pngu_pkg::CFG_WIDTH:     m_width = val[11:0];
      pngu_pkg::CFG_HEIGHT:    m_height = val;
      pngu_pkg::CFG_MODE:      m_mode = val[2:0];
      pngu_pkg::CFG_KEY_EN:    m_key_en = val[0];
      pngu_pkg::CFG_KEY_RED:   m_key_red = val[7:0];
      pngu_pkg::CFG_KEY_GREEN: m_key_green = val[7:0];
      pngu_pkg::CFG_KEY_BLUE:  m_key_blue = val[7:0];
      default: ;
    endcase
  endtask

  task automatic unfilter_word(pngu_pkg::in_word_t w);
    int unsigned v, ch, stride, h, col, a, b, c, k;
    int unsigned s[4];
    logic [31:0] e;
    pngu_pkg::out_word_t px;
    bit          last;
    px = '0;
    if (w.func) begin
      palette[w.entry_index] = {w.entry_red, w.entry_green, w.entry_blue, w.entry_alpha};
      return;
    end
    if (err_latched) return;
    v = w.stream_byte;
    if (want_filter) begin
      if (v > 4) begin
        err_latched = 1;
        px.bad_filter = 1;
        pixel_q.push_back(px);
      end else begin
        row_filt = v[2:0];
        want_filter = 0;
        byte_col = 0;
        left_pix = 0;
        upleft_pix = 0;
        pend_chan = 0;
      end
      return;
    end
    ch = chan_count(m_mode);
    stride = row_len();
    h = (m_height != 0) ? m_height : 1;
    col = byte_col;
    a = (left_pix >> (8 * (ch - 1))) & 8'hff;
    c = (upleft_pix >> (8 * (ch - 1))) & 8'hff;
    b = (row_num != 0 && col < pngu_pkg::ROW_BYTES_DEF) ? row_mem[col] : 0;
    case (row_filt)
      pngu_pkg::FILT_SUB:   v = v + a;
      pngu_pkg::FILT_UP:    v = v + b;
      pngu_pkg::FILT_AVG:   v = v + ((a + b) >> 1);
      pngu_pkg::FILT_PAETH: v = v + paeth_pick(a, b, c);
      default: ;
    endcase
    v = v & 8'hff;
    left_pix = (left_pix << 8) | v;
    upleft_pix = (upleft_pix << 8) | b;
    if (col < pngu_pkg::ROW_BYTES_DEF) row_mem[col] = v[7:0];
    k = col % ch;
    if (k == 0) pend_chan = 0;
    for (int i = 0; i < 4; i++)
      s[i] = (i < k && i < 3) ? ((pend_chan >> (8 * i)) & 8'hff) : 0;
    s[k] = v;
    if (k < 3) pend_chan = pend_chan | (v[7:0] << (8 * k));
    last = (k == ch - 1);
    px.row_end = (col + 1 >= stride);
    if (px.row_end) begin
      want_filter = 1;
      byte_col = 0;
      if (row_num + 1 >= h) begin
        px.image_end = 1;
        row_num = 0;
      end else begin
        row_num = row_num + 1;
      end
    end else begin
      byte_col = col + 1;
    end
    if (!last && !px.row_end) return;
    px.alpha = pngu_pkg::ALPHA_OPAQUE;
    case (m_mode)
      pngu_pkg::MODE_RGB: begin
        px.red = 8'(s[0]);
        px.green = 8'(s[1]);
        px.blue = 8'(s[2]);
        if (m_key_en && s[0] == m_key_red && s[1] == m_key_green && s[2] == m_key_blue)
          px.alpha = 0;
      end
      pngu_pkg::MODE_INDEXED: begin
        e = palette[s[0]];
        {px.red, px.green, px.blue, px.alpha} = e;
      end
      pngu_pkg::MODE_GRAY_ALPHA: begin
        px.red = 8'(s[0]);
        px.green = 8'(s[0]);
        px.blue = 8'(s[0]);
        px.alpha = 8'(s[1]);
      end
      pngu_pkg::MODE_RGBA: begin
        px.red = 8'(s[0]);
        px.green = 8'(s[1]);
        px.blue = 8'(s[2]);
        px.alpha = 8'(s[3]);
      end
      default: begin
        px.red = 8'(s[0]);
        px.green = 8'(s[0]);
        px.blue = 8'(s[0]);
        if (m_key_en && s[0] == m_key_red) px.alpha = 0;
      end
    endcase
    pixel_q.push_back(px);
  endtask

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("png_scanline_unfilter_to_rgba test failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pngu_pkg::out_word_t px;
    if (rst_ni && pop && !empty) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected word: %p", out_word_o);
        err_cnt++;
      end else begin
        px = pixel_q.pop_front();
        if (out_word_o.red !== px.red) begin
          $error("red: expected %0d, got %0d", px.red, out_word_o.red);
          err_cnt++;
        end
        if (out_word_o.green !== px.green) begin
          $error("green: expected %0d, got %0d", px.green, out_word_o.green);
          err_cnt++;
        end
        if (out_word_o.blue !== px.blue) begin
          $error("blue: expected %0d, got %0d", px.blue, out_word_o.blue);
          err_cnt++;
        end
        if (out_word_o.alpha !== px.alpha) begin
          $error("alpha: expected %0d, got %0d", px.alpha, out_word_o.alpha);
          err_cnt++;
        end
        if (out_word_o.row_end !== px.row_end) begin
          $error("row_end: expected %0d, got %0d", px.row_end, out_word_o.row_end);
          err_cnt++;
        end
        if (out_word_o.image_end !== px.image_end) begin
          $error("image_end: expected %0d, got %0d", px.image_end, out_word_o.image_end);
          err_cnt++;
        end
        if (out_word_o.bad_filter !== px.bad_filter) begin
          $error("bad_filter: expected %0d, got %0d", px.bad_filter, out_word_o.bad_filter);
          err_cnt++;
        end
      end
    end
  end

  // result side: random stalls and long hold-off
  initial begin
    int unsigned gap;
    gap = 0;
    forever begin
      @(negedge clk_i);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else if (gap > 0) begin
        pop <= 1'b0;
        gap--;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        gap = $urandom_range(0, 9);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_word(pngu_pkg::in_word_t w);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    push <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    unfilter_word(w);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(int unsigned v);
    pngu_pkg::in_word_t w;
    w = pngu_pkg::in_word_t'(IN_W'({$urandom, $urandom}));
    w.func = 1'b0;
    w.stream_byte = v[7:0];
    send_word(w);
  endtask

  task automatic send_entry(int unsigned idx, int unsigned r, int unsigned g,
                            int unsigned b, int unsigned a);
    pngu_pkg::in_word_t w;
    w = pngu_pkg::in_word_t'(IN_W'({$urandom, $urandom}));
    w.func = 1'b1;
    w.entry_index = idx[7:0];
    w.entry_red = r[7:0];
    w.entry_green = g[7:0];
    w.entry_blue = b[7:0];
    w.entry_alpha = a[7:0];
    send_word(w);
  endtask

  task automatic send_rand_entry();
    send_entry($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // one row with random samples, palette writes mixed in
  task automatic send_row(int unsigned filt);
    int unsigned n;
    n = row_len();
    send_byte(filt);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_rand_entry();
      send_byte($urandom_range(0, 255));
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    model_cfg(idx, val[15:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_image(int unsigned mode, int unsigned width, int unsigned height);
    settle();
    cfg_write(pngu_pkg::CFG_MODE, mode);
    cfg_write(pngu_pkg::CFG_WIDTH, width);
    cfg_write(pngu_pkg::CFG_HEIGHT, height);
  endtask

  task automatic test_filters();
    set_image(pngu_pkg::MODE_GRAY, 4, 6);
    send_byte(pngu_pkg::FILT_NONE);
    send_byte(0);
    send_byte(255);
    send_byte(128);
    send_byte(1);
    for (int unsigned f = pngu_pkg::FILT_SUB; f <= pngu_pkg::FILT_PAETH; f++) send_row(f);
    send_row(pngu_pkg::FILT_PAETH);
  endtask

  task automatic test_modes();
    for (int unsigned m = 0; m < 8; m++) begin
      set_image(m, 3, 2);
      send_row($urandom_range(0, 4));
      send_row($urandom_range(0, 4));
    end
  endtask

  task automatic test_palette();
    settle();
    send_entry(0, 1, 2, 3, 4);
    send_entry(255, 255, 254, 253, 0);
    send_entry(17, 80, 90, 100, 110);
    set_image(pngu_pkg::MODE_INDEXED, 5, 1);
    send_byte(pngu_pkg::FILT_NONE);
    send_byte(0);
    send_byte(255);
    send_byte(17);
    send_byte(200);
    send_byte(42);
  endtask

  task automatic test_key();
    set_image(pngu_pkg::MODE_GRAY, 3, 1);
    cfg_write(pngu_pkg::CFG_KEY_EN, 1);
    cfg_write(pngu_pkg::CFG_KEY_RED, 77);
    cfg_write(pngu_pkg::CFG_KEY_GREEN, 0);
    cfg_write(pngu_pkg::CFG_KEY_BLUE, 255);
    send_byte(pngu_pkg::FILT_NONE);
    send_byte(77);
    send_byte(78);
    send_byte(77);
    set_image(pngu_pkg::MODE_RGB, 3, 1);
    send_byte(pngu_pkg::FILT_NONE);
    send_byte(77); send_byte(0); send_byte(255);
    send_byte(77); send_byte(0); send_byte(254);
    send_byte(76); send_byte(0); send_byte(255);
    set_image(pngu_pkg::MODE_GRAY_ALPHA, 1, 1);
    send_byte(pngu_pkg::FILT_NONE);
    send_byte(77);
    send_byte(9);
    settle();
    cfg_write(pngu_pkg::CFG_KEY_EN, 0);
    set_image(pngu_pkg::MODE_GRAY, 1, 1);
    send_byte(pngu_pkg::FILT_NONE);
    send_byte(77);
  endtask

  task automatic test_sizes();
    set_image(pngu_pkg::MODE_GRAY, 0, 0);
    send_row(pngu_pkg::FILT_SUB);
    send_row(pngu_pkg::FILT_UP);
    set_image(pngu_pkg::MODE_RGB, 2, 65535);
    for (int i = 0; i < 3; i++) send_row($urandom_range(0, 4));
    settle();
    cfg_write(pngu_pkg::CFG_HEIGHT, 1);
    send_row(pngu_pkg::FILT_AVG);
  endtask

  // mode switch in the middle of a row leaves a short last pixel
  task automatic test_live_mode();
    set_image(pngu_pkg::MODE_RGB, 2, 1);
    send_byte(pngu_pkg::FILT_SUB);
    for (int i = 0; i < 4; i++) send_byte($urandom_range(0, 255));
    settle();
    cfg_write(pngu_pkg::CFG_MODE, pngu_pkg::MODE_GRAY_ALPHA);
    send_byte($urandom_range(0, 255));
  endtask

  task automatic test_backpressure();
    set_image(pngu_pkg::MODE_RGBA, 8, 3);
    pop_hold = 300;
    for (int i = 0; i < 3; i++) send_row($urandom_range(0, 4));
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned stop_at, width, rows;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      width = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 6);
      rows = $urandom_range(1, 4);
      set_image($urandom_range(0, 7), width, rows);
      if ($urandom_range(0, 1)) begin
        cfg_write(pngu_pkg::CFG_KEY_EN, $urandom_range(0, 1));
        cfg_write(pngu_pkg::CFG_KEY_RED, $urandom_range(0, 255));
        cfg_write(pngu_pkg::CFG_KEY_GREEN, $urandom_range(0, 255));
        cfg_write(pngu_pkg::CFG_KEY_BLUE, $urandom_range(0, 255));
      end
      if (m_mode == pngu_pkg::MODE_INDEXED)
        repeat ($urandom_range(1, 8)) send_rand_entry();
      repeat (rows) send_row($urandom_range(0, 4));
    end
  endtask

  // error latches until reset, so this runs last
  task automatic test_bad_filter();
    set_image(pngu_pkg::MODE_GRAY, 2, 1);
    send_row(pngu_pkg::FILT_NONE);
    send_byte(5);
    send_byte(pngu_pkg::FILT_NONE);
    send_byte(255);
    send_entry(3, 9, 8, 7, 6);
    send_byte(12);
  endtask

  initial begin
    model_reset();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_filters();
    test_modes();
    test_palette();
    test_key();
    test_sizes();
    test_live_mode();
    test_backpressure();
    test_random(550);
    settle();
    gaps_on = 1'b0;
    test_random(150);
    test_bad_filter();
    settle();
    if (err_cnt == 0) begin
      $display("png_scanline_unfilter_to_rgba test passed");
    end else begin
      $display("png_scanline_unfilter_to_rgba test failed");
    end
    $finish;
  end

endmodule
